[hdl/spectrum_bar_level_smoother_defines.svh]
// Assertion macros for the spectrum bar level smoother.
// Included by the top level; no other dependencies.
`ifndef SPECTRUM_BAR_LEVEL_SMOOTHER_DEFINES_SVH
`define SPECTRUM_BAR_LEVEL_SMOOTHER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define SBLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SBLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sbls_pkg.sv]
// Shared widths, register codes and types for the spectrum bar level smoother.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbls_pkg;

    localparam int COL_W      = 6;
    localparam int BIN_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int KEEP_W     = 8;
    localparam int LEVEL_W    = 16;
    localparam int COLOR_W    = 5;
    localparam int AMP_W      = 8;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int COLUMNS_DEF = 64;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_KEEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_KEEP = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd1280;
    localparam logic [KEEP_W-1:0] RISE_KEEP_RST = 8'd38;
    localparam logic [KEEP_W-1:0] FALL_KEEP_RST = 8'd230;

    // Partial square root: remainder and root so far
    typedef struct packed {
        logic [10:0] rem;
        logic [7:0]  root;
    } isqrt_t;

    // Item leaving the amplitude pipeline
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] column;
        logic [AMP_W-1:0] amp;
    } amp_item_t;

    // One digit of a restoring square root: bring down two bits, try 4r+1
    function automatic isqrt_t isqrt_step(input isqrt_t cur, input logic [1:0] pair);
        isqrt_t      nxt;
        logic [10:0] acc;
        logic [10:0] trial;
        acc   = {cur.rem[8:0], pair};
        trial = {1'b0, cur.root, 2'b01};
        if (acc >= trial)
        begin
            nxt.rem  = acc - trial;
            nxt.root = {cur.root[6:0], 1'b1};
        end
        else
        begin
            nxt.rem  = acc;
            nxt.root = {cur.root[6:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

[hdl/sbls_amp.sv]
// Amplitude pipeline: squares, gain scaling and square root of one FFT bin.
// Depends on sbls_pkg; six stages, all advanced by one shared enable.
`default_nettype none

module sbls_amp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [sbls_pkg::COL_W-1:0]    in_column,
    input  wire logic [sbls_pkg::BIN_W-1:0]    in_real,
    input  wire logic [sbls_pkg::BIN_W-1:0]    in_imag,
    input  wire logic [sbls_pkg::GAIN_W-1:0]   gain,
    output logic      [sbls_pkg::COL_W-1:0]    pre_column,
    output sbls_pkg::amp_item_t                amp_item
);
    import sbls_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [COL_W-1:0]        col1_reg, col2_reg, col3_reg, col4_reg, col5_reg, col6_reg;
    logic signed [BIN_W-1:0] re1_reg, im1_reg;
    logic [31:0]             re_sq2_reg, im_sq2_reg, g_sq2_reg;
    logic [31:0]             sq3_reg, g_sq3_reg;
    logic                    sat4_reg, sat5_reg;
    logic [15:0]             y4_reg;
    logic [7:0]              y5_low_reg;
    isqrt_t                  st5_reg;
    logic [AMP_W-1:0]        amp6_reg;

    logic signed [31:0]      re_sq, im_sq;
    logic [63:0]             prod;
    isqrt_t                  st5_next, st6;
    logic [AMP_W-1:0]        amp6_next;

    // Square both parts and the gain
    assign re_sq = re1_reg * re1_reg;
    assign im_sq = im1_reg * im1_reg;

    // Scale the squared magnitude by the squared gain
    assign prod = 64'(sq3_reg) * 64'(g_sq3_reg);

    // Upper four root digits
    always_comb
    begin
        st5_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            st5_next = isqrt_step(st5_next, y4_reg[15 - 2*i -: 2]);
        end
    end

    // Lower four root digits, saturate at full scale
    always_comb
    begin
        st6 = st5_reg;
        for (int i = 0; i < 4; i++)
        begin
            st6 = isqrt_step(st6, y5_low_reg[7 - 2*i -: 2]);
        end
        amp6_next = sat5_reg ? {AMP_W{1'b1}} : st6.root;
    end

    // Advance stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col1_reg   <= in_column;
            re1_reg    <= in_real;
            im1_reg    <= in_imag;

            col2_reg   <= col1_reg;
            re_sq2_reg <= unsigned'(re_sq);
            im_sq2_reg <= unsigned'(im_sq);
            g_sq2_reg  <= 32'(gain) * 32'(gain);

            col3_reg   <= col2_reg;
            sq3_reg    <= re_sq2_reg + im_sq2_reg;
            g_sq3_reg  <= g_sq2_reg;

            // Root of the product over 2^16; any bit above 2^32 means amp > 255
            col4_reg   <= col3_reg;
            sat4_reg   <= |prod[63:32];
            y4_reg     <= prod[31:16];

            col5_reg   <= col4_reg;
            sat5_reg   <= sat4_reg;
            y5_low_reg <= y4_reg[7:0];
            st5_reg    <= st5_next;

            col6_reg   <= col5_reg;
            amp6_reg   <= amp6_next;
        end
    end

    assign pre_column      = col5_reg;
    assign amp_item.valid  = v6_reg;
    assign amp_item.column = col6_reg;
    assign amp_item.amp    = amp6_reg;

endmodule

`default_nettype wire

[hdl/sbls_level_store.sv]
// Per-column level memory with registered read and write bypass.
// Depends on sbls_pkg; entries never written read as zero through valid bits.
`default_nettype none

module sbls_level_store #(
    parameter int COLUMNS = sbls_pkg::COLUMNS_DEF,
    parameter int IDX_W   = $clog2(COLUMNS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [IDX_W-1:0]              rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [sbls_pkg::LEVEL_W-1:0]  wr_data,
    output logic      [sbls_pkg::LEVEL_W-1:0]  rd_level
);
    import sbls_pkg::*;

    logic [LEVEL_W-1:0] mem [COLUMNS];
    logic [COLUMNS-1:0] written_reg;
    logic [LEVEL_W-1:0] rd_data_reg;
    logic [LEVEL_W-1:0] byp_data_reg;
    logic               rd_written_reg;
    logic               byp_hit_reg;

    // Write the array and register the read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // Track written entries and same-address collisions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
                byp_hit_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Forward a colliding write, otherwise cleared entries read as zero
    always_comb
    begin
        priority if (byp_hit_reg)
            rd_level = byp_data_reg;
        else if (rd_written_reg)
            rd_level = rd_data_reg;
        else
            rd_level = '0;
    end

endmodule

`default_nettype wire

[hdl/spectrum_bar_level_smoother.sv]
// Spectrum bar level smoother: top level with config registers and level update.
// Depends on sbls_pkg, sbls_amp, sbls_level_store and the defines header.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one transaction per FFT bin: the bar column
//   and the complex bin. m_tvalid/m_tready/m_tdata return one transaction per
//   input with the column, its new Q8.8 level and a palette index.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write gain (0), rise_keep (1) and
//   fall_keep (2); other indexes are dropped. Write them only while idle.
//   Throughput is one transaction per cycle unless m_tready stalls the output,
//   set by a pipeline of six stages that share one enable and a level memory
//   read one stage ahead of its read-modify-write; the result is then registered.
//   Back-to-back updates of one column are forwarded inside the memory.
//   Reset clears all levels to zero through per-entry written flags and loads
//   the default register values; no clearing pass is needed.
//   When m_tready is low with a result pending, the whole pipeline holds and
//   s_tready drops in the same cycle.
//   Column numbers at or above COLUMNS wrap modulo COLUMNS.
`default_nettype none
`include "spectrum_bar_level_smoother_defines.svh"

module spectrum_bar_level_smoother #(
    parameter int COLUMNS = sbls_pkg::COLUMNS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // column [5:0], bin_real [21:6], bin_imag [37:22], zero [39:38]
    input  wire logic [sbls_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_column [5:0], level [21:6], color_index [26:22], zero [31:27]
    output logic      [sbls_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sbls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbls_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sbls_pkg::*;

    localparam int IDX_W = $clog2(COLUMNS);

    logic [GAIN_W-1:0]  gain_reg;
    logic [KEEP_W-1:0]  rise_keep_reg;
    logic [KEEP_W-1:0]  fall_keep_reg;
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_column_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic               en;
    logic [COL_W-1:0]   pre_column;
    amp_item_t          amp_item;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [LEVEL_W-1:0] wr_data;
    logic [LEVEL_W-1:0] rd_level;

    logic [LEVEL_W-1:0] amp_q;
    logic               rising;
    logic [23:0]        keep_prod;
    logic [8:0]         rise_share;
    logic [24:0]        amp_prod;
    logic [24:0]        rise_sum;
    logic [23:0]        fall_prod;
    logic [LEVEL_W-1:0] level_next;

    // Map a column number onto a store entry, wrapping at COLUMNS
    function automatic logic [IDX_W-1:0] col_to_idx(input logic [COL_W-1:0] c);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] res;
        r   = '0;
        res = '0;
        for (int i = 0; i < 2**COL_W; i++)
        begin
            if (c == COL_W'(i))
            begin
                res = r;
            end
            if (r == IDX_W'(COLUMNS - 1))
                r = '0;
            else
                r = r + 1'b1;
        end
        return res;
    endfunction

    // Advance everything unless a result waits on a stalled receiver
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Load configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            rise_keep_reg <= RISE_KEEP_RST;
            fall_keep_reg <= FALL_KEEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN:      gain_reg      <= cfg_data;
                REG_RISE_KEEP: rise_keep_reg <= cfg_data[KEEP_W-1:0];
                REG_FALL_KEEP: fall_keep_reg <= cfg_data[KEEP_W-1:0];
                default:       ;
            endcase
        end
    end

    sbls_amp u_amp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_column  (s_tdata[5:0]),
        .in_real    (s_tdata[21:6]),
        .in_imag    (s_tdata[37:22]),
        .gain       (gain_reg),
        .pre_column (pre_column),
        .amp_item   (amp_item)
    );

    // Read the level as the item enters the last amplitude stage
    assign rd_en   = en;
    assign rd_addr = col_to_idx(pre_column);

    sbls_level_store #(
        .COLUMNS (COLUMNS),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_level (rd_level)
    );

    // Rise toward the amplitude or decay
    always_comb
    begin
        amp_q      = {amp_item.amp, 8'h00};
        rising     = rd_level < amp_q;
        keep_prod  = 24'(rd_level) * 24'(rise_keep_reg);
        rise_share = 9'd256 - {1'b0, rise_keep_reg};
        amp_prod   = 25'(amp_q) * 25'(rise_share);
        rise_sum   = 25'(keep_prod) + amp_prod;
        fall_prod  = 24'(rd_level) * 24'(fall_keep_reg);
        level_next = rising ? rise_sum[23:8] : fall_prod[23:8];
    end

    // Write the new level back
    assign wr_en   = en && amp_item.valid;
    assign wr_addr = col_to_idx(amp_item.column);
    assign wr_data = level_next;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= amp_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_column_reg <= amp_item.column;
            out_level_reg  <= level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COL_W - LEVEL_W - COLOR_W){1'b0}},
                       out_level_reg[LEVEL_W-1 -: COLOR_W], out_level_reg, out_column_reg};

    `SBLS_ASSERT_NXT(a_result_lands, clk, rst_n, amp_item.valid && en, m_tvalid, "result lost")
    `SBLS_ASSERT_NXT(a_fwd_level, clk, rst_n, rd_en && wr_en && (rd_addr == wr_addr), rd_level == $past(wr_data), "collision not forwarded")
    `SBLS_ASSERT_NOW(a_level_ceiling, clk, rst_n, m_tvalid, out_level_reg <= 16'hFF00, "level above full scale")

endmodule

`default_nettype wire
